FILE: rtl/core/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, character codes and the microprogram of the line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned FILL_W = 5;
  localparam int unsigned PC_W   = 5;

  typedef logic [PC_W-1:0]   pc_t;
  typedef logic [FILL_W-1:0] fill_t;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_HIGH  = 8'hA0;
  localparam logic [7:0] CTRL_C   = 8'h63 & 8'h1F;
  localparam logic [7:0] CTRL_R   = 8'h72 & 8'h1F;
  localparam logic [7:0] CTRL_U   = 8'h75 & 8'h1F;
  localparam logic [7:0] CTRL_W   = 8'h77 & 8'h1F;

  typedef enum logic [2:0] {
    KIND_ECHO = 3'd0,
    KIND_LINE = 3'd1,
    KIND_EOF  = 3'd2,
    KIND_ERR  = 3'd3,
    KIND_INTR = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    VSEL_CONST,
    VSEL_CHAR,
    VSEL_STORE
  } vsel_e;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_CLEAR,
    FILL_PUSH,
    FILL_POP
  } fill_op_e;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_CLEAR,
    PTR_INC
  } ptr_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_FILL_ZERO,
    COND_PTR_AT_FILL,
    COND_TOP_SPACE,
    COND_FULL
  } cond_e;

  // One control word per microprogram step
  typedef struct packed {
    logic       emit;
    kind_e      kind;
    vsel_e      vsel;
    logic [7:0] vconst;
    fill_op_e   fill_op;
    ptr_op_e    ptr_op;
    logic       rd_top;   // read store at fill-1 instead of at the pointer
    cond_e      cond;
    pc_t        target;
    logic       done;
  } ucode_t;

  // Datapath status seen by the jump conditions
  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic ptr_at_fill;
    logic top_space;
  } dp_stat_t;

  // Program entry points and loop heads
  localparam pc_t PC_EOF     = 5'd0;
  localparam pc_t PC_ERR     = 5'd1;
  localparam pc_t PC_INTR    = 5'd2;
  localparam pc_t PC_DONE    = 5'd3;
  localparam pc_t PC_LF      = 5'd4;
  localparam pc_t PC_LF_LOOP = 5'd6;
  localparam pc_t PC_LF_END  = 5'd8;
  localparam pc_t PC_PRINT   = 5'd9;
  localparam pc_t PC_BEL     = 5'd11;
  localparam pc_t PC_ERASE   = 5'd12;
  localparam pc_t PC_REPRINT = 5'd16;
  localparam pc_t PC_RP_LOOP = 5'd17;
  localparam pc_t PC_KILL    = 5'd19;
  localparam pc_t PC_WERASE  = 5'd23;

  // CR reads as LF, tab as space
  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] m;
    m = c;
    if (c == CH_CR) begin
      m = CH_LF;
    end else if (c == CH_TAB) begin
      m = CH_SP;
    end
    return m;
  endfunction

  function automatic pc_t dispatch(input logic [7:0] c, input logic fe, input logic oe);
    logic [7:0] m;
    pc_t        pc;
    m = map_char(c);
    priority if (fe) begin
      pc = PC_EOF;
    end else if (oe) begin
      pc = PC_ERR;
    end else if (m == CH_LF) begin
      pc = PC_LF;
    end else if ((m >= CH_SP && m <= CH_TILDE) || m >= CH_HIGH) begin
      pc = PC_PRINT;
    end else if (m == CTRL_C) begin
      pc = PC_INTR;
    end else if (m == CH_BS || m == CH_DEL) begin
      pc = PC_ERASE;
    end else if (m == CTRL_R) begin
      pc = PC_REPRINT;
    end else if (m == CTRL_U) begin
      pc = PC_KILL;
    end else if (m == CTRL_W) begin
      pc = PC_WERASE;
    end else begin
      pc = PC_DONE;
    end
    return pc;
  endfunction

  // Microprogram ROM
  function automatic ucode_t ucode_fetch(input pc_t pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      PC_EOF: begin
        w.emit = 1'b1; w.kind = KIND_EOF; w.fill_op = FILL_CLEAR;
        w.cond = COND_ALWAYS; w.target = PC_DONE;
      end
      PC_ERR: begin
        w.emit = 1'b1; w.kind = KIND_ERR; w.fill_op = FILL_CLEAR;
        w.cond = COND_ALWAYS; w.target = PC_DONE;
      end
      PC_INTR: begin
        w.emit = 1'b1; w.kind = KIND_INTR; w.fill_op = FILL_CLEAR;
        w.cond = COND_ALWAYS; w.target = PC_DONE;
      end
      PC_DONE: begin
        w.done = 1'b1;
      end
      // end of line: echo CR LF, deliver the line, then LF
      PC_LF: begin
        w.emit = 1'b1; w.vconst = CH_CR;
      end
      PC_LF + 5'd1: begin
        w.emit = 1'b1; w.vconst = CH_LF; w.ptr_op = PTR_CLEAR;
      end
      PC_LF_LOOP: begin
        w.cond = COND_PTR_AT_FILL; w.target = PC_LF_END;
      end
      PC_LF_LOOP + 5'd1: begin
        w.emit = 1'b1; w.kind = KIND_LINE; w.vsel = VSEL_STORE;
        w.ptr_op = PTR_INC; w.cond = COND_ALWAYS; w.target = PC_LF_LOOP;
      end
      PC_LF_END: begin
        w.emit = 1'b1; w.kind = KIND_LINE; w.vconst = CH_LF;
        w.fill_op = FILL_CLEAR; w.cond = COND_ALWAYS; w.target = PC_DONE;
      end
      // printable: store and echo, or ring the bell
      PC_PRINT: begin
        w.cond = COND_FULL; w.target = PC_BEL;
      end
      PC_PRINT + 5'd1: begin
        w.emit = 1'b1; w.vsel = VSEL_CHAR; w.fill_op = FILL_PUSH;
        w.cond = COND_ALWAYS; w.target = PC_DONE;
      end
      PC_BEL: begin
        w.emit = 1'b1; w.vconst = CH_BEL;
        w.cond = COND_ALWAYS; w.target = PC_DONE;
      end
      // erase one
      PC_ERASE: begin
        w.cond = COND_FILL_ZERO; w.target = PC_DONE;
      end
      PC_ERASE + 5'd1: begin
        w.emit = 1'b1; w.vconst = CH_BS;
      end
      PC_ERASE + 5'd2: begin
        w.emit = 1'b1; w.vconst = CH_SP;
      end
      PC_ERASE + 5'd3: begin
        w.emit = 1'b1; w.vconst = CH_BS; w.fill_op = FILL_POP;
        w.cond = COND_ALWAYS; w.target = PC_DONE;
      end
      // reprint
      PC_REPRINT: begin
        w.emit = 1'b1; w.vconst = CH_CR; w.ptr_op = PTR_CLEAR;
      end
      PC_RP_LOOP: begin
        w.cond = COND_PTR_AT_FILL; w.target = PC_DONE;
      end
      PC_RP_LOOP + 5'd1: begin
        w.emit = 1'b1; w.vsel = VSEL_STORE; w.ptr_op = PTR_INC;
        w.cond = COND_ALWAYS; w.target = PC_RP_LOOP;
      end
      // line kill
      PC_KILL: begin
        w.cond = COND_FILL_ZERO; w.target = PC_DONE;
      end
      PC_KILL + 5'd1: begin
        w.emit = 1'b1; w.vconst = CH_BS;
      end
      PC_KILL + 5'd2: begin
        w.emit = 1'b1; w.vconst = CH_SP;
      end
      PC_KILL + 5'd3: begin
        w.emit = 1'b1; w.vconst = CH_BS; w.fill_op = FILL_POP;
        w.cond = COND_ALWAYS; w.target = PC_KILL;
      end
      // word erase
      PC_WERASE: begin
        w.cond = COND_FILL_ZERO; w.target = PC_DONE;
      end
      PC_WERASE + 5'd1: begin
        w.rd_top = 1'b1; w.cond = COND_TOP_SPACE; w.target = PC_DONE;
      end
      PC_WERASE + 5'd2: begin
        w.emit = 1'b1; w.vconst = CH_BS;
      end
      PC_WERASE + 5'd3: begin
        w.emit = 1'b1; w.vconst = CH_SP;
      end
      PC_WERASE + 5'd4: begin
        w.emit = 1'b1; w.vconst = CH_BS; w.fill_op = FILL_POP;
        w.cond = COND_ALWAYS; w.target = PC_WERASE;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/sle_seq.sv
// ----------------------------------------------------------------------------
// sle_seq
// Step counter, microprogram ROM and conditional jump logic.
// ----------------------------------------------------------------------------
module sle_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              advance_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              framing_error_i,
  input  logic              overrun_error_i,
  input  sle_pkg::dp_stat_t stat_i,
  output sle_pkg::ucode_t   uc_o,
  output logic              busy_o
);
  import sle_pkg::*;

  pc_t  pc_q, pc_d;
  logic busy_q, busy_d;
  logic take;

  assign uc_o   = ucode_fetch(pc_q);
  assign busy_o = busy_q;

  always_comb begin
    unique case (uc_o.cond)
      COND_NEVER:       take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_FILL_ZERO:   take = stat_i.fill_zero;
      COND_PTR_AT_FILL: take = stat_i.ptr_at_fill;
      COND_TOP_SPACE:   take = stat_i.top_space;
      COND_FULL:        take = stat_i.fill_full;
      default:          take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (accept_i) begin
      pc_d   = dispatch(rx_byte_i, framing_error_i, overrun_error_i);
      busy_d = 1'b1;
    end else if (advance_i) begin
      if (uc_o.done) begin
        busy_d = 1'b0;
      end else if (take) begin
        pc_d = uc_o.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PC_DONE;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

endmodule

FILE: rtl/core/sle_dp.sv
// ----------------------------------------------------------------------------
// sle_dp
// Line store, fill count, read pointer and result value selection.
// ----------------------------------------------------------------------------
module sle_dp #(
  parameter int unsigned LINE_LENGTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              advance_i,
  input  logic [7:0]        rx_byte_i,
  input  sle_pkg::ucode_t   uc_i,
  output sle_pkg::dp_stat_t stat_o,
  output logic [7:0]        value_o
);
  import sle_pkg::*;

  localparam int unsigned DEPTH = LINE_LENGTH - 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam fill_t       FULL  = fill_t'(DEPTH);

  logic [7:0] store_q [DEPTH];
  fill_t      fill_q, fill_d;
  fill_t      ptr_q, ptr_d;
  logic [7:0] char_q;
  fill_t      rd_addr;
  logic [7:0] rd_data;

  assign rd_addr = uc_i.rd_top ? (fill_q - 1'b1) : ptr_q;
  assign rd_data = store_q[rd_addr[IDX_W-1:0]];

  assign stat_o.fill_zero   = (fill_q == '0);
  assign stat_o.fill_full   = (fill_q >= FULL);
  assign stat_o.ptr_at_fill = (ptr_q == fill_q);
  assign stat_o.top_space   = (rd_data == CH_SP);

  always_comb begin
    unique case (uc_i.vsel)
      VSEL_CONST: value_o = uc_i.vconst;
      VSEL_CHAR:  value_o = char_q;
      VSEL_STORE: value_o = rd_data;
      default:    value_o = CH_NUL;
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    ptr_d  = ptr_q;
    if (advance_i) begin
      unique case (uc_i.fill_op)
        FILL_HOLD:  fill_d = fill_q;
        FILL_CLEAR: fill_d = '0;
        FILL_PUSH:  fill_d = fill_q + 1'b1;
        FILL_POP:   fill_d = fill_q - 1'b1;
        default:    fill_d = fill_q;
      endcase
      unique case (uc_i.ptr_op)
        PTR_HOLD:  ptr_d = ptr_q;
        PTR_CLEAR: ptr_d = '0;
        PTR_INC:   ptr_d = ptr_q + 1'b1;
        default:   ptr_d = ptr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ptr_q  <= '0;
    end else begin
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
    end
  end

  // Hold the mapped character; append it to the line on a push
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      char_q <= map_char(rx_byte_i);
    end
    if (advance_i && uc_i.fill_op == FILL_PUSH) begin
      store_q[fill_q[IDX_W-1:0]] <= char_q;
    end
  end

endmodule

FILE: rtl/core/serial_line_editor_core.sv
// ----------------------------------------------------------------------------
// serial_line_editor_core
// Canonical-mode line editor for bytes from a serial receiver.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries one received byte with its
// framing and overrun flags. Output channel (out_valid_o / out_ready_i)
// carries result requests: kind, value and last, where last marks the final
// request caused by one input byte. A byte that causes no result (ignored
// control code, erase on an empty line) produces nothing on the output.
//
// One byte is worked on at a time: in_ready_o is high only while the
// sequencer is idle. After dispatch the sequencer runs one microprogram
// step per cycle while no stalled result holds it. Results pass through a
// one-entry hold register (so the last flag is known) and then the output
// register.
// A stalled receiver stalls only the steps that must move a result; other
// steps keep going. Reset empties the line and drops any pending request;
// the line store itself is not cleared.
// ----------------------------------------------------------------------------
module serial_line_editor_core #(
  parameter int unsigned LINE_LENGTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       framing_error_i,
  input  logic       overrun_error_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] value_o,
  output logic       last_o
);
  import sle_pkg::*;

  ucode_t     uc;
  dp_stat_t   stat;
  logic       busy;
  logic       accept;
  logic       advance;
  logic       flush;
  logic       out_free;
  logic [7:0] emit_value;

  // hold register: one result waits here until we know whether it is last
  logic       hold_valid_q;
  kind_e      hold_kind_q;
  logic [7:0] hold_value_q;

  logic       out_valid_q;
  kind_e      out_kind_q;
  logic [7:0] out_value_q;
  logic       out_last_q;

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;

  // A new emit or the final step pushes the held result toward the output
  assign flush    = busy && hold_valid_q && (uc.emit || uc.done);
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = busy && !(flush && !out_free);

  sle_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .advance_i       (advance),
    .rx_byte_i       (rx_byte_i),
    .framing_error_i (framing_error_i),
    .overrun_error_i (overrun_error_i),
    .stat_i          (stat),
    .uc_o            (uc),
    .busy_o          (busy)
  );

  sle_dp #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .advance_i (advance),
    .rx_byte_i (rx_byte_i),
    .uc_i      (uc),
    .stat_o    (stat),
    .value_o   (emit_value)
  );

  // Control state of the hold and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        if (uc.emit) begin
          hold_valid_q <= 1'b1;
        end else if (uc.done) begin
          hold_valid_q <= 1'b0;
        end
      end
      if (advance && flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (advance && uc.emit) begin
      hold_kind_q  <= uc.kind;
      hold_value_q <= emit_value;
    end
    if (advance && flush) begin
      out_kind_q  <= hold_kind_q;
      out_value_q <= hold_value_q;
      out_last_q  <= uc.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign value_o     = out_value_q;
  assign last_o      = out_last_q;

endmodule

FILE: rtl/core/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks for the line editor, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] kind_o,
  input logic [7:0] value_o,
  input logic       last_o
);
  import sle_pkg::*;

  // One byte at a time: an accepted request blocks the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous byte still in work");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(kind_o) && $stable(value_o) && $stable(last_o))
    else $error("stalled result changed");

  // Abort kinds are the sole result of their byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_EOF || kind_o == KIND_ERR || kind_o == KIND_INTR)
      |-> last_o && value_o == CH_NUL)
    else $error("abort result not alone or carries a value");

  // Only defined kinds leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o == KIND_ECHO || kind_o == KIND_LINE ||
      kind_o == KIND_EOF || kind_o == KIND_ERR || kind_o == KIND_INTR)
    else $error("undefined result kind");

endmodule

bind serial_line_editor_core sle_checker u_sle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .value_o     (value_o),
  .last_o      (last_o)
);

FILE: tb/serial_line_editor_core_test.sv
// ----------------------------------------------------------------------------
// serial_line_editor_core_test
// Self-checking bench for the serial line editor core.
// ----------------------------------------------------------------------------
// Received bytes go in on the input channel. A shadow copy of the line store
// and fill count predicts the echo, delivery and abort requests that each
// byte causes. Every request taken from the output channel is compared
// field by field with the oldest prediction. Both channels idle at random
// between requests, with steady stretches in between. A short directed pass
// covers the special keys and field extremes. Full-line fills and random
// edited lines mixed with noise bytes follow.
// ----------------------------------------------------------------------------
module serial_line_editor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int unsigned LINE_LENGTH = 16;
  localparam int unsigned USABLE      = LINE_LENGTH - 1;
  localparam int          TOTAL_ITEMS = 110;
  // Cycles to let pass once nothing is expected, enough for a silent byte
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       rx_valid    = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte     = 8'h00;
  logic       framing_err = 1'b0;
  logic       overrun_err = 1'b0;
  logic       res_valid;
  logic       res_ready   = 1'b0;
  logic [2:0] res_kind;
  logic [7:0] res_value;
  logic       res_last;

  // Shadow of the editor state
  logic [7:0] shadow_line [USABLE];
  int         shadow_fill = 0;

  result_t expected_results [$];
  result_t reply [$];
  int      sent_bytes     = 0;
  int      mismatch_count = 0;
  bit      no_gaps        = 1'b0;

  serial_line_editor_core #(
    .LINE_LENGTH(LINE_LENGTH)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (rx_valid),
    .in_ready_o     (rx_ready),
    .rx_byte_i      (rx_byte),
    .framing_error_i(framing_err),
    .overrun_error_i(overrun_err),
    .out_valid_o    (res_valid),
    .out_ready_i    (res_ready),
    .kind_o         (res_kind),
    .value_o        (res_value),
    .last_o         (res_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void add_reply(input kind_e kind, input logic [7:0] value);
    result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = 1'b0;
    reply.push_back(r);
  endfunction

  // Echo BS, space, BS and drop the newest character
  function automatic void rub_out_char();
    add_reply(KIND_ECHO, CH_BS);
    add_reply(KIND_ECHO, CH_SP);
    add_reply(KIND_ECHO, CH_BS);
    shadow_fill--;
  endfunction

  function automatic void predict_edit(input logic [7:0] raw, input logic fe, input logic oe);
    logic [7:0] c;
    int         i;
    c = raw;
    reply.delete();
    if (fe) begin
      add_reply(KIND_EOF, 8'h00);
      shadow_fill = 0;
    end else if (oe) begin
      add_reply(KIND_ERR, 8'h00);
      shadow_fill = 0;
    end else begin
      if (c == CH_CR) begin
        c = CH_LF;
      end else if (c == CH_TAB) begin
        c = CH_SP;
      end
      if (c == CH_LF) begin
        add_reply(KIND_ECHO, CH_CR);
        add_reply(KIND_ECHO, CH_LF);
        for (i = 0; i < shadow_fill; i++) begin
          add_reply(KIND_LINE, shadow_line[i]);
        end
        add_reply(KIND_LINE, CH_LF);
        shadow_fill = 0;
      end else if ((c >= CH_SP && c <= CH_TILDE) || c >= CH_HIGH) begin
        if (shadow_fill >= USABLE) begin
          add_reply(KIND_ECHO, CH_BEL);
        end else begin
          shadow_line[shadow_fill] = c;
          shadow_fill++;
          add_reply(KIND_ECHO, c);
        end
      end else if (c == CTRL_C) begin
        add_reply(KIND_INTR, 8'h00);
        shadow_fill = 0;
      end else if (c == CH_BS || c == CH_DEL) begin
        if (shadow_fill > 0) begin
          rub_out_char();
        end
      end else if (c == CTRL_R) begin
        add_reply(KIND_ECHO, CH_CR);
        for (i = 0; i < shadow_fill; i++) begin
          add_reply(KIND_ECHO, shadow_line[i]);
        end
      end else if (c == CTRL_U) begin
        while (shadow_fill > 0) begin
          rub_out_char();
        end
      end else if (c == CTRL_W) begin
        while (shadow_fill > 0 && shadow_line[shadow_fill-1] != CH_SP) begin
          rub_out_char();
        end
      end
    end
    if (reply.size() > 0) begin
      reply[reply.size()-1].last = 1'b1;
    end
    foreach (reply[j]) begin
      expected_results.push_back(reply[j]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Offer one byte, hold it until taken, then update the shadow
  task automatic send_byte(input logic [7:0] b, input logic fe, input logic oe);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid    <= 1'b1;
    rx_byte     <= b;
    framing_err <= fe;
    overrun_err <= oe;
    do @(posedge clk); while (!rx_ready);
    sent_bytes++;
    predict_edit(b, fe, oe);
  endtask

  function automatic logic [7:0] rand_printable();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return $urandom_range(0, 1) ? CH_SP : CH_TAB;
    end else if (pick == 1) begin
      return 8'($urandom_range(32'hA0, 32'hFF));
    end
    return 8'($urandom_range(32'h21, 32'h7E));
  endfunction

  function automatic logic [7:0] rand_edit_key();
    case ($urandom_range(0, 4))
      0: return CH_BS;
      1: return CH_DEL;
      2: return CTRL_W;
      3: return CTRL_R;
      default: return CTRL_U;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && res_valid && res_ready) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected request: kind=%0d value=%02h last=%0b",
                               res_kind, res_value, res_last));
      end else begin
        want = expected_results.pop_front();
        if (res_kind !== want.kind || res_value !== want.value || res_last !== want.last) begin
          note_failure($sformatf(
            "request mismatch: expected kind=%0d value=%02h last=%0b, got kind=%0d value=%02h last=%0b",
            want.kind, want.value, want.last, res_kind, res_value, res_last));
        end
      end
    end
  end

  // Result side: drop ready at random before each request, except in gap-free stretches
  initial begin : result_ready_driver
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!(res_valid && res_ready));
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Control codes with no meaning, then edits and an end of line on an empty line
  task automatic test_empty_line_keys();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h9F, 1'b0, 1'b0);
    send_byte(CH_BS, 1'b0, 1'b0);
    send_byte(CTRL_U, 1'b0, 1'b0);
    send_byte(CTRL_W, 1'b0, 1'b0);
    send_byte(CTRL_R, 1'b0, 1'b0);
    send_byte(CH_LF, 1'b0, 1'b0);
  endtask

  // Printable extremes, tab mapping, word erase up to a space, erase, reprint, CR
  task automatic test_printable_and_edits();
    no_gaps = 1'b1;
    send_byte(CH_TILDE, 1'b0, 1'b0);
    send_byte(CH_TAB, 1'b0, 1'b0);
    send_byte(CH_HIGH, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    no_gaps = 1'b0;
    send_byte(CTRL_W, 1'b0, 1'b0);
    send_byte(CH_DEL, 1'b0, 1'b0);
    send_byte(CTRL_R, 1'b0, 1'b0);
    send_byte(CH_CR, 1'b0, 1'b0);
  endtask

  // Framing beats overrun, overrun alone, then Ctrl-C; each clears the line
  task automatic test_line_aborts();
    send_byte(8'h78, 1'b0, 1'b0);
    send_byte(CH_LF, 1'b1, 1'b1);
    send_byte(8'h79, 1'b0, 1'b0);
    send_byte(8'h7A, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(CTRL_C, 1'b0, 1'b0);
  endtask

  // Fill the store past its end, then reprint, word-erase, deliver and kill
  task automatic test_full_line();
    int k;
    for (k = 0; k <= USABLE; k++) begin
      send_byte(8'($urandom_range(32'h21, 32'h7E)), 1'b0, 1'b0);
    end
    send_byte(CTRL_R, 1'b0, 1'b0);
    send_byte(CTRL_W, 1'b0, 1'b0);
    for (k = 0; k < USABLE; k++) begin
      send_byte(rand_printable(), 1'b0, 1'b0);
    end
    send_byte(CH_CR, 1'b0, 1'b0);
    no_gaps = 1'b1;
    for (k = 0; k < USABLE; k++) begin
      send_byte(rand_printable(), 1'b0, 1'b0);
    end
    send_byte(CTRL_U, 1'b0, 1'b0);
    no_gaps = 1'b0;
  endtask

  // Mostly edited lines with a random ending, the rest noise bytes
  task automatic test_random_lines(input int items);
    int         target;
    int         len;
    int         k;
    logic [7:0] b;
    target = sent_bytes + items;
    while (sent_bytes < target) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(0, 17);
        for (k = 0; k < len && sent_bytes < target; k++) begin
          b = ($urandom_range(0, 7) == 0) ? rand_edit_key() : rand_printable();
          send_byte(b, 1'b0, 1'b0);
        end
        case ($urandom_range(0, 9))
          0, 1, 2: send_byte(CH_CR, 1'b0, 1'b0);
          3, 4:    send_byte(CH_LF, 1'b0, 1'b0);
          5:       send_byte(CTRL_U, 1'b0, 1'b0);
          6:       send_byte(CTRL_C, 1'b0, 1'b0);
          7:       send_byte(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
          8:       send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          default: ;  // leave the line open
        endcase
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0),
                    1'($urandom_range(0, 7) == 0));
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_line_keys();
    test_printable_and_edits();
    test_line_aborts();
    test_full_line();
    test_random_lines(TOTAL_ITEMS - sent_bytes);

    // Drop valid, then drain what is still owed
    rx_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
